FILE: src/blvm_pkg.sv
// Package for the battery low-voltage monitor.
// Config and queue entry types, register indexes and reset values.
// No dependencies.
package blvm_pkg;

   localparam int SAMPLE_W = 10;
   localparam int REF_W    = 13;
   localparam int MV_W     = 16;
   localparam int LIMIT_W  = 8;
   localparam int PCT_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_REF_MV        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MV       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_MV        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CHARGE_MV = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE      = 3'd4;

   localparam logic [REF_W-1:0]   RST_REF_MV        = 13'd2560;
   localparam logic [MV_W-1:0]    RST_FULL_MV       = 16'd12600;
   localparam logic [MV_W-1:0]    RST_LOW_MV        = 16'd10500;
   localparam logic [MV_W-1:0]    RST_MIN_CHARGE_MV = 16'd5000;
   localparam logic [LIMIT_W-1:0] RST_DEBOUNCE      = 8'd10;

   localparam logic [MV_W-1:0]  MV_MAX   = 16'hFFFF;
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
   localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;

   typedef struct packed {
      logic [REF_W-1:0]   ref_mv;
      logic [MV_W-1:0]    full_mv;
      logic [MV_W-1:0]    low_mv;
      logic [MV_W-1:0]    min_charge_mv;
      logic [LIMIT_W-1:0] debounce_limit;
   } cfg_type;

   // one converted transaction, as it waits between front and back
   typedef struct packed {
      logic [MV_W-1:0] battery_mv;
      logic            battery_ok;
      logic [MV_W-1:0] charger_mv;
      logic            charger_ok;
   } entry_type;

endpackage

FILE: src/blvm_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on blvm_pkg for field widths.
interface blvm_req_if;
   import blvm_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] battery_sample;
   logic                battery_sample_ok;
   logic [SAMPLE_W-1:0] charger_sample;
   logic                charger_sample_ok;

   modport source (output valid, battery_sample, battery_sample_ok,
                   charger_sample, charger_sample_ok, input ready);
   modport sink   (input valid, battery_sample, battery_sample_ok,
                   charger_sample, charger_sample_ok, output ready);
endinterface

interface blvm_rsp_if;
   import blvm_pkg::*;
   logic             valid;
   logic             ready;
   logic [MV_W-1:0]  battery_millivolts;
   logic [MV_W-1:0]  charger_millivolts;
   logic [PCT_W-1:0] charge_percent;
   logic             low_condition;
   logic             power_off;

   modport source (output valid, battery_millivolts, charger_millivolts,
                   charge_percent, low_condition, power_off, input ready);
   modport sink   (input valid, battery_millivolts, charger_millivolts,
                   charge_percent, low_condition, power_off, output ready);
endinterface

FILE: src/blvm_front.sv
// Front end: accepts request transactions and converts ADC codes to millivolts.
// Depends on blvm_pkg and blvm_req_if.
module blvm_front (
   input  logic               clock,
   input  logic               reset,
   input  blvm_pkg::cfg_type  cfg,
   blvm_req_if.sink           req_ch,
   output logic               push,
   output blvm_pkg::entry_type push_data,
   input  logic               full
);
   import blvm_pkg::*;

   localparam int PROD_W = SAMPLE_W + REF_W;   // sample * ref
   localparam int X11_W  = PROD_W + 4;         // times 11

   logic                hold_valid_ff, hold_valid_in;
   logic [SAMPLE_W-1:0] bat_ff, bat_in;
   logic [SAMPLE_W-1:0] chg_ff, chg_in;
   logic                bat_ok_ff, bat_ok_in;
   logic                chg_ok_ff, chg_ok_in;

   logic [PROD_W-1:0]   bat_prod, chg_prod;
   logic [X11_W-1:0]    bat_x11, chg_x11;
   logic [X11_W-11:0]   bat_raw, chg_raw;

   assign push          = hold_valid_ff && !full;
   assign req_ch.ready  = !hold_valid_ff || !full;

   assign bat_prod = PROD_W'(bat_ff) * PROD_W'(cfg.ref_mv);
   assign chg_prod = PROD_W'(chg_ff) * PROD_W'(cfg.ref_mv);
   assign bat_x11  = (X11_W'(bat_prod) << 3) + (X11_W'(bat_prod) << 1) + X11_W'(bat_prod);
   assign chg_x11  = (X11_W'(chg_prod) << 3) + (X11_W'(chg_prod) << 1) + X11_W'(chg_prod);
   assign bat_raw  = bat_x11[X11_W-1:10];
   assign chg_raw  = chg_x11[X11_W-1:10];

   always_comb begin
      push_data.battery_mv = (bat_raw > (X11_W-10)'(MV_MAX)) ? MV_MAX : bat_raw[MV_W-1:0];
      push_data.charger_mv = (chg_raw > (X11_W-10)'(MV_MAX)) ? MV_MAX : chg_raw[MV_W-1:0];
      push_data.battery_ok = bat_ok_ff;
      push_data.charger_ok = chg_ok_ff;
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      bat_in    = bat_ff;
      chg_in    = chg_ff;
      bat_ok_in = bat_ok_ff;
      chg_ok_in = chg_ok_ff;
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (req_ch.valid && req_ch.ready) begin
         hold_valid_in = 1'b1;
         bat_in    = req_ch.battery_sample;
         chg_in    = req_ch.charger_sample;
         bat_ok_in = req_ch.battery_sample_ok;
         chg_ok_in = req_ch.charger_sample_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      bat_ff    <= bat_in;
      chg_ff    <= chg_in;
      bat_ok_ff <= bat_ok_in;
      chg_ok_ff <= chg_ok_in;
   end

endmodule

FILE: src/blvm_queue.sv
// Small register FIFO between front and back.
// Depends on blvm_pkg for the entry type.
module blvm_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  blvm_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output blvm_pkg::entry_type pop_data,
   output logic                empty
);
   import blvm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/blvm_back.sv
// Back end: voltage state, debounce counter, power-off latch and the
// iterative percentage divider; drives the response channel.
// Depends on blvm_pkg and blvm_rsp_if.
module blvm_back (
   input  logic                clock,
   input  logic                reset,
   input  blvm_pkg::cfg_type   cfg,
   input  blvm_pkg::entry_type entry,
   input  logic                empty,
   output logic                pop,
   blvm_rsp_if.source          rsp_ch
);
   import blvm_pkg::*;

   localparam int NUM_W = MV_W + PCT_W;        // (v - low) * 100 fits here
   localparam int DSH_W = MV_W + PCT_W - 1;    // divisor << (PCT_W-1)
   localparam int STEP_W = $clog2(PCT_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [MV_W-1:0]    bat_level_ff, bat_level_in;
   logic [MV_W-1:0]    chg_level_ff, chg_level_in;
   logic [LIMIT_W-1:0] low_count_ff, low_count_in;
   logic               latch_ff, latch_in;
   logic               low_ff, low_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [DSH_W-1:0]   dsh_ff, dsh_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [PCT_W-1:0]   pct_ff, pct_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]    rsp_bat_ff, rsp_bat_in;
   logic [MV_W-1:0]    rsp_chg_ff, rsp_chg_in;
   logic [PCT_W-1:0]   rsp_pct_ff, rsp_pct_in;
   logic               rsp_low_ff, rsp_low_in;
   logic               rsp_off_ff, rsp_off_in;

   logic [MV_W-1:0]    nb, nc, diff;
   logic               low_now;

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.battery_millivolts = rsp_bat_ff;
   assign rsp_ch.charger_millivolts = rsp_chg_ff;
   assign rsp_ch.charge_percent     = rsp_pct_ff;
   assign rsp_ch.low_condition      = rsp_low_ff;
   assign rsp_ch.power_off          = rsp_off_ff;

   assign pop     = (state_ff == ST_IDLE) && !empty;
   assign nb      = entry.battery_ok ? entry.battery_mv : bat_level_ff;
   assign nc      = entry.charger_ok ? entry.charger_mv : chg_level_ff;
   assign low_now = (nb < cfg.low_mv) && (nc < cfg.min_charge_mv);
   assign diff    = nb - cfg.low_mv;

   always_comb begin
      state_in     = state_ff;
      bat_level_in = bat_level_ff;
      chg_level_in = chg_level_ff;
      low_count_in = low_count_ff;
      latch_in     = latch_ff;
      low_in       = low_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      step_in      = step_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bat_in   = rsp_bat_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_off_in   = rsp_off_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               bat_level_in = nb;
               chg_level_in = nc;
               low_in       = low_now;
               if (low_now) begin
                  // compare against the count before the advance
                  if (low_count_ff > cfg.debounce_limit) begin
                     latch_in     = 1'b1;
                     low_count_in = '0;
                  end else begin
                     low_count_in = low_count_ff + 1'b1;
                  end
               end else begin
                  low_count_in = '0;
               end
               rem_in  = (NUM_W'(diff) << 6) + (NUM_W'(diff) << 5) + (NUM_W'(diff) << 2);
               dsh_in  = DSH_W'(cfg.full_mv - cfg.low_mv) << (PCT_W - 1);
               step_in = STEP_W'(PCT_W - 1);
               pct_in  = '0;
               if (nb >= cfg.full_mv) begin
                  pct_in   = PCT_FULL;
                  state_in = ST_LOAD;
               end else if (nb <= cfg.low_mv) begin
                  pct_in   = PCT_ZERO;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_ff >= NUM_W'(dsh_ff)) begin
               rem_in = rem_ff - NUM_W'(dsh_ff);
               pct_in = {pct_ff[PCT_W-2:0], 1'b1};
            end else begin
               pct_in = {pct_ff[PCT_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            if (step_ff == '0) begin
               state_in = ST_LOAD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bat_in   = bat_level_ff;
               rsp_chg_in   = chg_level_ff;
               rsp_pct_in   = pct_ff;
               rsp_low_in   = low_ff;
               rsp_off_in   = latch_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bat_level_ff <= '0;
         chg_level_ff <= '0;
         low_count_ff <= '0;
         latch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bat_level_ff <= bat_level_in;
         chg_level_ff <= chg_level_in;
         low_count_ff <= low_count_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      low_ff     <= low_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      step_ff    <= step_in;
      pct_ff     <= pct_in;
      rsp_bat_ff <= rsp_bat_in;
      rsp_chg_ff <= rsp_chg_in;
      rsp_pct_ff <= rsp_pct_in;
      rsp_low_ff <= rsp_low_in;
      rsp_off_ff <= rsp_off_in;
   end

endmodule

FILE: src/battery_low_voltage_monitor_top.sv
// Top level of the battery low-voltage monitor: csr registers, front end,
// queue and back end. Depends on blvm_pkg, blvm_if, blvm_front, blvm_queue, blvm_back.
//
//   channel  dir  handshake          contents
//   req_ch   in   valid/ready        battery/charger ADC codes with ok flags
//   rsp_ch   out  valid/ready        millivolts, percent, low flag, power-off
//   csr_*    in   csr_wr_en only     register index and write data
//
// A transaction passes the front end hold register, then is popped and updates
// state in the back end, then runs the restoring percentage divider (skipped
// at 0 or 100 percent), then loads the output. The back end takes no new entry
// until the last one is loaded into the output; the queue buffers meanwhile.
// Synchronous active-high reset clears state, queue and handshakes; csr
// registers return to defaults. A stalled response holds the back end while
// the front end and queue keep taking transactions until full.
module battery_low_voltage_monitor_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   blvm_req_if.sink                        req_ch,
   blvm_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [blvm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [blvm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import blvm_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type push_data, pop_data;
   logic      push, pop, full, empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_REF_MV:        cfg_in.ref_mv         = csr_wdata[REF_W-1:0];
            CSR_FULL_MV:       cfg_in.full_mv        = csr_wdata[MV_W-1:0];
            CSR_LOW_MV:        cfg_in.low_mv         = csr_wdata[MV_W-1:0];
            CSR_MIN_CHARGE_MV: cfg_in.min_charge_mv  = csr_wdata[MV_W-1:0];
            CSR_DEBOUNCE:      cfg_in.debounce_limit = csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_mv         <= RST_REF_MV;
         cfg_ff.full_mv        <= RST_FULL_MV;
         cfg_ff.low_mv         <= RST_LOW_MV;
         cfg_ff.min_charge_mv  <= RST_MIN_CHARGE_MV;
         cfg_ff.debounce_limit <= RST_DEBOUNCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   blvm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_ch    (req_ch),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   blvm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   blvm_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .entry  (pop_data),
      .empty  (empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

FILE: sim/battery_low_voltage_monitor_top_test.sv
// Self-checking testbench for battery_low_voltage_monitor_top.
// Drives sample transactions, predicts millivolts, percent, low flag and
// power-off latch in-line, and checks every response. Depends on blvm_pkg, blvm_if.
module battery_low_voltage_monitor_top_test;
   import blvm_pkg::*;

   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_ITEMS    = 220;
   localparam int WRAP_ITEMS     = 300;

   typedef struct packed {
      logic [SAMPLE_W-1:0] battery_code;
      logic                battery_ok;
      logic [SAMPLE_W-1:0] charger_code;
      logic                charger_ok;
   } sample_type;

   typedef struct packed {
      logic [MV_W-1:0]  battery_mv;
      logic [MV_W-1:0]  charger_mv;
      logic [PCT_W-1:0] percent;
      logic             low_flag;
      logic             power_off;
   } reading_type;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   blvm_req_if req_ch();
   blvm_rsp_if rsp_ch();

   battery_low_voltage_monitor_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state and register copy
   cfg_type            model_cfg = '{RST_REF_MV, RST_FULL_MV, RST_LOW_MV,
                                     RST_MIN_CHARGE_MV, RST_DEBOUNCE};
   logic [MV_W-1:0]    bat_level = '0;
   logic [MV_W-1:0]    chg_level = '0;
   logic [LIMIT_W-1:0] low_count = '0;
   logic               shutdown  = 1'b0;

   reading_type pending_readings[$];
   int          mismatch_count = 0;
   int          burst_left = 0;
   bit          gaps_on = 1'b1;
   int          quiet_cycles = 0;
   rx_mode_type stall_mode = RX_ALWAYS;
   int          stall_left = 0;
   int unsigned rx_tick = 0;

   function automatic logic [MV_W-1:0] sample_to_mv(logic [SAMPLE_W-1:0] code);
      longint unsigned mv;
      mv = code;
      mv = (mv * model_cfg.ref_mv * 11) >> 10;
      if (mv > MV_MAX)
         return MV_MAX;
      return mv[MV_W-1:0];
   endfunction

   function automatic logic [PCT_W-1:0] percent_of(logic [MV_W-1:0] v);
      int unsigned span;
      if (v >= model_cfg.full_mv)
         return PCT_FULL;
      if (v <= model_cfg.low_mv)
         return PCT_ZERO;
      span = model_cfg.full_mv - model_cfg.low_mv;
      return PCT_W'(((v - model_cfg.low_mv) * 100) / span);
   endfunction

   function automatic reading_type predict_reading(sample_type s);
      reading_type        r;
      logic [LIMIT_W-1:0] prev;
      logic               is_low;
      if (s.battery_ok)
         bat_level = sample_to_mv(s.battery_code);
      if (s.charger_ok)
         chg_level = sample_to_mv(s.charger_code);
      is_low = (bat_level < model_cfg.low_mv) && (chg_level < model_cfg.min_charge_mv);
      if (is_low) begin
         prev = low_count;
         low_count = low_count + 1'b1;
         if (prev > model_cfg.debounce_limit) begin
            shutdown  = 1'b1;
            low_count = '0;
         end
      end else begin
         low_count = '0;
      end
      r.battery_mv = bat_level;
      r.charger_mv = chg_level;
      r.percent    = percent_of(bat_level);
      r.low_flag   = is_low;
      r.power_off  = shutdown;
      return r;
   endfunction

   function automatic sample_type make_sample(int bat, bit bok, int chg, bit cok);
      sample_type s;
      s.battery_code = SAMPLE_W'(bat);
      s.battery_ok   = bok;
      s.charger_code = SAMPLE_W'(chg);
      s.charger_ok   = cok;
      return s;
   endfunction

   // ADC code whose voltage lands near mv, shifted by an offset in [off_lo, off_hi]
   function automatic logic [SAMPLE_W-1:0] code_near(int unsigned mv, int off_lo, int off_hi);
      longint step;
      longint c;
      if (model_cfg.ref_mv == 0)
         return SAMPLE_W'($urandom_range(0, 1023));
      step = longint'(model_cfg.ref_mv) * 11;
      c = (longint'(mv) * 1024) / step;
      c = c + off_lo + longint'($urandom_range(0, off_hi - off_lo));
      if (c < 0)
         c = 0;
      if (c > 1023)
         c = 1023;
      return SAMPLE_W'(c);
   endfunction

   function automatic bit rand_ok();
      return $urandom_range(0, 9) != 0;
   endfunction

   // battery below the low threshold and charger below the charging minimum
   function automatic sample_type low_sample();
      sample_type s;
      s.battery_code = code_near(model_cfg.low_mv, -40, -1);
      s.charger_code = code_near(model_cfg.min_charge_mv, -40, -1);
      s.battery_ok   = rand_ok();
      s.charger_ok   = rand_ok();
      if (!s.battery_ok)
         s.battery_code = SAMPLE_W'($urandom_range(0, 1023));
      if (!s.charger_ok)
         s.charger_code = SAMPLE_W'($urandom_range(0, 1023));
      return s;
   endfunction

   function automatic sample_type mixed_sample();
      sample_type  s;
      int unsigned target;
      if ($urandom_range(0, 9) < 3) begin
         s = make_sample(int'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                         int'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
         return s;
      end
      case ($urandom_range(0, 2))
         0: target = model_cfg.low_mv;
         1: target = model_cfg.full_mv;
         default: begin
            if (model_cfg.full_mv > model_cfg.low_mv)
               target = model_cfg.low_mv
                        + $urandom_range(0, model_cfg.full_mv - model_cfg.low_mv);
            else
               target = model_cfg.low_mv;
         end
      endcase
      s.battery_code = code_near(target, -3, 3);
      if ($urandom_range(0, 1))
         s.charger_code = code_near(model_cfg.min_charge_mv, -3, 3);
      else
         s.charger_code = SAMPLE_W'($urandom_range(0, 1023));
      s.battery_ok = rand_ok();
      s.charger_ok = rand_ok();
      return s;
   endfunction

   task automatic send_sample(sample_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = gaps_on ? $urandom_range(1, 24) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid             <= 1'b1;
      req_ch.battery_sample    <= s.battery_code;
      req_ch.battery_sample_ok <= s.battery_ok;
      req_ch.charger_sample    <= s.charger_code;
      req_ch.charger_sample_ok <= s.charger_ok;
      do @(posedge clock); while (!req_ch.ready);
      pending_readings.push_back(predict_reading(s));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_REF_MV:        model_cfg.ref_mv         = data[REF_W-1:0];
         CSR_FULL_MV:       model_cfg.full_mv        = data;
         CSR_LOW_MV:        model_cfg.low_mv         = data;
         CSR_MIN_CHARGE_MV: model_cfg.min_charge_mv  = data;
         CSR_DEBOUNCE:      model_cfg.debounce_limit = data[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // registers only change with nothing in flight
   task automatic set_config(logic [CSR_DATA_W-1:0] ref_mv, logic [CSR_DATA_W-1:0] full_mv,
                             logic [CSR_DATA_W-1:0] low_mv, logic [CSR_DATA_W-1:0] min_mv,
                             logic [CSR_DATA_W-1:0] limit);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_csr(CSR_REF_MV, ref_mv);
      write_csr(CSR_FULL_MV, full_mv);
      write_csr(CSR_LOW_MV, low_mv);
      write_csr(CSR_MIN_CHARGE_MV, min_mv);
      write_csr(CSR_DEBOUNCE, limit);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_conversion_extremes();
      send_sample(make_sample(10'h3FF, 1'b0, 10'h3FF, 1'b0));  // levels still zero
      send_sample(make_sample(1023, 1'b1, 1023, 1'b1));
      send_sample(make_sample(0, 1'b1, 0, 1'b1));
      send_sample(make_sample(1023, 1'b0, 1023, 1'b1));
      send_sample(make_sample(381, 1'b1, 181, 1'b1));
      send_sample(make_sample(382, 1'b1, 181, 1'b1));
      send_sample(make_sample(381, 1'b1, 182, 1'b1));
      send_sample(make_sample(458, 1'b1, 1023, 1'b1));
      send_sample(make_sample(459, 1'b1, 0, 1'b0));
      send_sample(make_sample(400, 1'b1, 10'h2AA, 1'b1));
      send_sample(make_sample(10'h155, 1'b1, 10'h2AA, 1'b0));
   endtask

   task automatic test_saturation_and_percent_bounds();
      // upper bits of the reference write are dropped; full == low
      set_config(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd254);
      send_sample(make_sample(1023, 1'b1, 1023, 1'b1));
      send_sample(make_sample(1, 1'b1, 0, 1'b1));
      send_sample(make_sample(0, 1'b1, 1, 1'b1));
      // zero reference and full below low
      set_config(16'd0, 16'd1000, 16'hFFFF, 16'd0, 16'd254);
      send_sample(make_sample(1023, 1'b1, 1023, 1'b1));
      send_sample(make_sample(512, 1'b0, 512, 1'b1));
   endtask

   task automatic test_unknown_register();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      for (int i = CSR_DEBOUNCE + 1; i < 2 ** CSR_IDX_W; i++)
         write_csr(CSR_IDX_W'(i), 16'hFFFF);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      send_sample(make_sample(700, 1'b1, 300, 1'b1));
      send_sample(make_sample(5, 1'b1, 5, 1'b1));
   endtask

   task automatic test_counter_wrap();
      set_config(CSR_DATA_W'(RST_REF_MV), RST_FULL_MV, RST_LOW_MV, RST_MIN_CHARGE_MV,
                 16'hFFFF);
      gaps_on = 1'b1;
      repeat (WRAP_ITEMS) send_sample(low_sample());
   endtask

   task automatic test_power_off_latch();
      set_config(CSR_DATA_W'(RST_REF_MV), RST_FULL_MV, RST_LOW_MV, RST_MIN_CHARGE_MV,
                 16'd3);
      send_sample(make_sample(1023, 1'b1, 1023, 1'b1));  // clears the count
      repeat (6) send_sample(make_sample(100, 1'b1, 50, 1'b1));
      send_sample(make_sample(1023, 1'b1, 0, 1'b1));
      repeat (2) send_sample(make_sample(100, 1'b1, 50, 1'b1));
   endtask

   task automatic run_random_phase(int n);
      int  sent;
      int  run;
      bit  low_run;
      sent = 0;
      gaps_on = $urandom_range(0, 3) != 0;
      while (sent < n) begin
         low_run = $urandom_range(0, 2) != 0;
         run = low_run ? $urandom_range(1, 30) : $urandom_range(1, 8);
         for (int k = 0; k < run && sent < n; k++) begin
            if (sent == n / 2)
               wait_drained();
            send_sample(low_run ? low_sample() : mixed_sample());
            sent++;
         end
      end
   endtask

   task automatic test_random_settings();
      cfg_type settings[7] = '{
         '{13'd2560, 16'd12600, 16'd10500, 16'd5000,  8'd10},
         '{13'd1000, 16'd4200,  16'd3000,  16'd2000,  8'd0},
         '{13'd5000, 16'd20000, 16'd15000, 16'd8000,  8'd254},
         '{13'd8191, 16'd65535, 16'd0,     16'd65535, 8'd1},
         '{13'd1000, 16'd0,     16'd65535, 16'd0,     8'd5},
         '{13'd3300, 16'd12000, 16'd9000,  16'd6000,  8'd255},
         '{13'd4096, 16'd30000, 16'd10000, 16'd30000, 8'd20}
      };
      foreach (settings[i]) begin
         set_config(CSR_DATA_W'(settings[i].ref_mv), settings[i].full_mv,
                    settings[i].low_mv, settings[i].min_charge_mv,
                    CSR_DATA_W'(settings[i].debounce_limit));
         run_random_phase(PHASE_ITEMS);
      end
   endtask

   // response side: stall pattern is redrawn at random after each random-length run
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            if (stall_left == 0) begin
               stall_mode = rx_mode_type'($urandom_range(0, 3));
               stall_left = $urandom_range(32, 400);
            end
            stall_left--;
            rx_tick++;
            case (stall_mode)
               RX_ALWAYS: rsp_ch.ready <= 1'b1;
               RX_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ch.ready <= (rx_tick % 8) == 0;
               default:   rsp_ch.ready <= rx_tick[0];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.battery_millivolts, rsp_ch.charger_millivolts,
                 rsp_ch.charge_percent, rsp_ch.low_condition, rsp_ch.power_off};
         if (pending_readings.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected response: bat=%0d chg=%0d pct=%0d low=%0b off=%0b",
                        got.battery_mv, got.charger_mv, got.percent, got.low_flag,
                        got.power_off);
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            if (got !== want) begin
               if (mismatch_count < MAX_REPORTS)
                  $display({"mismatch: exp bat=%0d chg=%0d pct=%0d low=%0b off=%0b",
                            " | got bat=%0d chg=%0d pct=%0d low=%0b off=%0b"},
                           want.battery_mv, want.charger_mv, want.percent,
                           want.low_flag, want.power_off, got.battery_mv,
                           got.charger_mv, got.percent, got.low_flag, got.power_off);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: cycles without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.battery_sample = '0;
      req_ch.battery_sample_ok = 1'b0;
      req_ch.charger_sample = '0;
      req_ch.charger_sample_ok = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_conversion_extremes();
      test_saturation_and_percent_bounds();
      test_unknown_register();
      test_counter_wrap();
      test_power_off_latch();
      test_random_settings();

      wait_drained();
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (mismatch_count == 0 && pending_readings.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
src/blvm_pkg.sv
src/blvm_if.sv
src/blvm_front.sv
src/blvm_queue.sv
src/blvm_back.sv
src/battery_low_voltage_monitor_top.sv
sim/battery_low_voltage_monitor_top_test.sv
